// ===== hw/rtl/cdfe_pkg.sv =====
// Package for the clock date field editor: request and field codes, BCD helpers, clamps.
`default_nettype none

package cdfe_pkg;

	// request codes carried in req_type
	typedef enum logic [2:0] {
		REQ_LOAD  = 3'd0,
		REQ_TICK  = 3'd1,
		REQ_MINUS = 3'd2,
		REQ_PLUS  = 3'd3,
		REQ_NEXT  = 3'd4
	} req_t;

	// selected field codes carried in field_sel
	typedef enum logic [2:0] {
		FLD_YEAR   = 3'd0,
		FLD_MONTH  = 3'd1,
		FLD_DAY    = 3'd2,
		FLD_HOUR   = 3'd3,
		FLD_MINUTE = 3'd4,
		FLD_DONE   = 3'd5
	} field_t;

	localparam int unsigned LIMIT_W       = 4;
	localparam logic [3:0]  LIMIT_RESET   = 4'd10;

	localparam logic [6:0]  YEAR_MAX      = 7'd99;
	localparam logic [6:0]  MONTH_MIN     = 7'd1;
	localparam logic [6:0]  MONTH_MAX     = 7'd12;
	localparam logic [6:0]  DAY_MIN       = 7'd1;
	localparam logic [6:0]  DAY_MAX       = 7'd31;
	localparam logic [6:0]  HOUR_MAX      = 7'd23;
	localparam logic [6:0]  MINUTE_MAX    = 7'd59;
	localparam logic [6:0]  VAL_ZERO      = 7'd0;

	localparam logic [3:0]  MON_FEB       = 4'd2;
	localparam logic [3:0]  MON_APR       = 4'd4;
	localparam logic [3:0]  MON_JUN       = 4'd6;
	localparam logic [3:0]  MON_SEP       = 4'd9;
	localparam logic [3:0]  MON_NOV       = 4'd11;

	// two BCD nibbles to binary, nibbles above nine taken at face value
	function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'b0, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
	endfunction

	// clamp a converted load value into its static range
	function automatic logic [6:0] clamp_load(input logic [7:0] x,
			input logic [6:0] lo, input logic [6:0] hi);
		logic [6:0] r;
		if (x < {1'b0, lo})
			r = lo;
		else if (x > {1'b0, hi})
			r = hi;
		else
			r = x[6:0];
		return r;
	endfunction

	// step by -1, +1 or 0 and clamp to lo..hi
	function automatic logic [6:0] step_val(input logic [6:0] v, input logic dn,
			input logic up, input logic [6:0] lo, input logic [6:0] hi);
		logic [6:0] r;
		if (dn)
			r = (v <= lo) ? lo : (((v - 7'd1) > hi) ? hi : (v - 7'd1));
		else if (up)
			r = (v >= hi) ? hi : (((v + 7'd1) < lo) ? lo : (v + 7'd1));
		else
			r = (v < lo) ? lo : ((v > hi) ? hi : v);
		return r;
	endfunction

	// day limit of the month; leap when the year is a multiple of four
	function automatic logic [6:0] days_in_month(input logic [3:0] month,
			input logic leap);
		logic [6:0] r;
		if (month == MON_FEB)
			r = leap ? 7'd29 : 7'd28;
		else if (month == MON_APR || month == MON_JUN || month == MON_SEP ||
				month == MON_NOV)
			r = 7'd30;
		else
			r = DAY_MAX;
		return r;
	endfunction

	// binary 0..99 to two BCD digits; tens by reciprocal multiply (x*205 >> 11)
	function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  rem;
		p    = {8'b0, v} * 15'd205;
		tens = p[14:11];
		rem  = v - ({tens, 3'b0} + {2'b0, tens, 1'b0});
		return {tens, rem[3:0]};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clock_date_field_editor.sv =====
// Top level of the clock date field editor: input stage, edit logic, result register.
// A word accepted into the input register (stage 1) moves on into the result register once
// that register is free or drained; its result is taken from the result register.
// Throughput: one word per cycle; in_stall rises only while stage 1 holds a word, the result
// register is full and out_stall is high.
// Reset: arst_n low clears the edit state, the idle count and both valid flags at once;
// the inactivity limit returns to 10.
`default_nettype none

module clock_date_field_editor
	import cdfe_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [LIMIT_W-1:0]  cfg_data,
	// input words
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          req_type,
	input  wire logic [7:0]          load_year_bcd,
	input  wire logic [4:0]          load_month_bcd,
	input  wire logic [5:0]          load_day_bcd,
	input  wire logic [5:0]          load_hour_bcd,
	input  wire logic [6:0]          load_minute_bcd,
	// result words
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     editing,
	output logic [2:0]               field_sel,
	output logic [7:0]               year_bcd,
	output logic [4:0]               month_bcd,
	output logic [5:0]               day_bcd,
	output logic [5:0]               hour_bcd,
	output logic [6:0]               minute_bcd,
	output logic                     commit,
	output logic                     abandoned
);

	// configuration register, always ready
	logic [LIMIT_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (cfg_valid && cfg_ready)
			limit_q <= cfg_data;
	end

	// handshake: stage 1 moves on when the result register is free or drained
	logic valid_s1;
	logic adv;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	// input register
	req_t       req_s1;
	logic [7:0] ld_year_s1;
	logic [4:0] ld_month_s1;
	logic [5:0] ld_day_s1;
	logic [5:0] ld_hour_s1;
	logic [6:0] ld_minute_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1       <= req_t'(req_type);
			ld_year_s1   <= load_year_bcd;
			ld_month_s1  <= load_month_bcd;
			ld_day_s1    <= load_day_bcd;
			ld_hour_s1   <= load_hour_bcd;
			ld_minute_s1 <= load_minute_bcd;
		end
	end

	// edit state
	logic       active_q;
	field_t     field_q;
	logic [6:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [3:0] idle_q;

	// next state
	logic       active_n;
	field_t     field_n;
	logic [6:0] year_n;
	logic [3:0] month_n;
	logic [4:0] day_n;
	logic [4:0] hour_n;
	logic [5:0] minute_n;
	logic [3:0] idle_n;
	logic       commit_n;
	logic       abandon_n;

	// step request toward the per-field clamps
	logic       do_step;
	field_t     step_f;
	logic       step_dn;
	logic       step_up;
	logic [6:0] day_hi;

	assign day_hi = days_in_month(month_q, year_q[1:0] == 2'b00);

	// request decode
	always_comb begin
		active_n  = active_q;
		field_n   = field_q;
		idle_n    = idle_q;
		commit_n  = 1'b0;
		abandon_n = 1'b0;
		do_step   = 1'b0;
		step_f    = field_q;
		step_dn   = 1'b0;
		step_up   = 1'b0;
		if (req_s1 == REQ_LOAD) begin
			active_n = 1'b1;
			field_n  = FLD_YEAR;
			idle_n   = '0;
		end else if (active_q) begin
			unique case (req_s1)
				REQ_TICK: begin
					if (idle_q >= limit_q) begin
						active_n  = 1'b0;
						abandon_n = 1'b1;
						idle_n    = '0;
					end else begin
						idle_n = idle_q + 4'd1;
					end
				end
				REQ_MINUS, REQ_PLUS: begin
					do_step = 1'b1;
					step_dn = (req_s1 == REQ_MINUS);
					step_up = (req_s1 == REQ_PLUS);
					idle_n  = '0;
				end
				REQ_NEXT: begin
					idle_n = '0;
					if (field_q == FLD_MINUTE || field_q == FLD_DONE) begin
						field_n  = FLD_DONE;
						active_n = 1'b0;
						commit_n = 1'b1;
					end else begin
						field_n = field_t'(3'(field_q + 3'd1));
						step_f  = field_n;
						do_step = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// field values: load, or step and clamp the selected field
	always_comb begin
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		if (req_s1 == REQ_LOAD) begin
			year_n   = clamp_load(bcd_to_bin(ld_year_s1), VAL_ZERO, YEAR_MAX);
			month_n  = 4'(clamp_load(bcd_to_bin({3'b0, ld_month_s1}), MONTH_MIN,
				MONTH_MAX));
			day_n    = 5'(clamp_load(bcd_to_bin({2'b0, ld_day_s1}), DAY_MIN, DAY_MAX));
			hour_n   = 5'(clamp_load(bcd_to_bin({2'b0, ld_hour_s1}), VAL_ZERO,
				HOUR_MAX));
			minute_n = 6'(clamp_load(bcd_to_bin({1'b0, ld_minute_s1}), VAL_ZERO,
				MINUTE_MAX));
		end else if (do_step) begin
			unique case (step_f)
				FLD_YEAR:   year_n = step_val(year_q, step_dn, step_up, VAL_ZERO, YEAR_MAX);
				FLD_MONTH:  month_n = 4'(step_val({3'b0, month_q}, step_dn, step_up,
					MONTH_MIN, MONTH_MAX));
				FLD_DAY:    day_n = 5'(step_val({2'b0, day_q}, step_dn, step_up,
					DAY_MIN, day_hi));
				FLD_HOUR:   hour_n = 5'(step_val({2'b0, hour_q}, step_dn, step_up,
					VAL_ZERO, HOUR_MAX));
				FLD_MINUTE: minute_n = 6'(step_val({1'b0, minute_q}, step_dn, step_up,
					VAL_ZERO, MINUTE_MAX));
				default: ;
			endcase
		end
	end

	// state update when the word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			field_q  <= FLD_YEAR;
			year_q   <= '0;
			month_q  <= 4'd1;
			day_q    <= 5'd1;
			hour_q   <= '0;
			minute_q <= '0;
			idle_q   <= '0;
		end else if (adv) begin
			active_q <= active_n;
			field_q  <= field_n;
			year_q   <= year_n;
			month_q  <= month_n;
			day_q    <= day_n;
			hour_q   <= hour_n;
			minute_q <= minute_n;
			idle_q   <= idle_n;
		end
	end

	// result register
	logic       out_valid_q;
	logic       editing_q;
	logic [2:0] field_sel_q;
	logic [7:0] year_bcd_q;
	logic [7:0] month_bcd_q;
	logic [7:0] day_bcd_q;
	logic [7:0] hour_bcd_q;
	logic [7:0] minute_bcd_q;
	logic       commit_q;
	logic       abandoned_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			editing_q    <= active_n;
			field_sel_q  <= field_n;
			year_bcd_q   <= bin_to_bcd(year_n);
			month_bcd_q  <= bin_to_bcd({3'b0, month_n});
			day_bcd_q    <= bin_to_bcd({2'b0, day_n});
			hour_bcd_q   <= bin_to_bcd({2'b0, hour_n});
			minute_bcd_q <= bin_to_bcd({1'b0, minute_n});
			commit_q     <= commit_n;
			abandoned_q  <= abandon_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign editing    = editing_q;
	assign field_sel  = field_sel_q;
	assign year_bcd   = year_bcd_q;
	assign month_bcd  = month_bcd_q[4:0];
	assign day_bcd    = day_bcd_q[5:0];
	assign hour_bcd   = hour_bcd_q[5:0];
	assign minute_bcd = minute_bcd_q[6:0];
	assign commit     = commit_q;
	assign abandoned  = abandoned_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cdfe_checker.sv =====
// Port-level checker for the clock date field editor and its bind to the top level.
`default_nettype none

module cdfe_checker
	import cdfe_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       editing,
	input wire logic [2:0] field_sel,
	input wire logic       commit,
	input wire logic       abandoned
);

	// a commit word closes the edit on the done field
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && commit |-> !editing && field_sel == FLD_DONE)
		else $error("commit word still editing or not on done field");

	// an abandon word ends editing and never coincides with commit
	a_abandon_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && abandoned |-> !editing && !commit)
		else $error("abandon word with editing or commit set");

	// while editing, the selection is one of the five value fields
	a_edit_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && editing |-> field_sel < FLD_DONE)
		else $error("editing with no value field selected");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(field_sel) &&
			$stable(editing) && $stable(commit))
		else $error("stalled result word changed");

endmodule

bind clock_date_field_editor cdfe_checker u_cdfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.editing   (editing),
	.field_sel (field_sel),
	.commit    (commit),
	.abandoned (abandoned)
);

`default_nettype wire
